/* hdl/nec_ir_pkg.sv */
package nec_ir_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER = 2'd0,
    CFG_ZERO   = 2'd1,
    CFG_ONE    = 2'd2,
    CFG_WRAP   = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] HeaderNominalRst = 16'd13500;
  localparam logic [15:0] ZeroNominalRst   = 16'd1124;
  localparam logic [15:0] OneNominalRst    = 16'd2248;
  localparam logic [31:0] WrapCountRst     = 32'hFFFF_FFFF;

  localparam logic [5:0]  FrameBits = 6'd32;
  localparam logic [31:0] MsbMask   = 32'h8000_0000;

  typedef struct packed {
    logic [15:0] header_nominal_us;
    logic [15:0] zero_nominal_us;
    logic [15:0] one_nominal_us;
    logic [31:0] wrap_count;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] address;
    logic [7:0] command;
  } frame_t;

endpackage

/* hdl/nec_ir_ifs.sv */
interface nec_ir_edge_if;
  logic        valid;
  logic        ready;
  logic [31:0] edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink   (input valid, input edge_time_us, output ready);
endinterface

interface nec_ir_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] address;
  logic [7:0] command;

  modport source (output valid, output address, output command, input ready);
  modport sink   (input valid, input address, input command, output ready);
endinterface

/* hdl/nec_ir_cfg.sv */
module nec_ir_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [nec_ir_pkg::CfgDataW-1:0]     cfg_data_i,
  output nec_ir_pkg::cfg_t                    cfg_o
);

  nec_ir_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (nec_ir_pkg::cfg_idx_e'(cfg_idx_i))
        nec_ir_pkg::CFG_HEADER: cfg_d.header_nominal_us = cfg_data_i[15:0];
        nec_ir_pkg::CFG_ZERO:   cfg_d.zero_nominal_us   = cfg_data_i[15:0];
        nec_ir_pkg::CFG_ONE:    cfg_d.one_nominal_us    = cfg_data_i[15:0];
        nec_ir_pkg::CFG_WRAP:   cfg_d.wrap_count        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_nominal_us <= nec_ir_pkg::HeaderNominalRst;
      cfg_q.zero_nominal_us   <= nec_ir_pkg::ZeroNominalRst;
      cfg_q.one_nominal_us    <= nec_ir_pkg::OneNominalRst;
      cfg_q.wrap_count        <= nec_ir_pkg::WrapCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/nec_ir_match.sv */
module nec_ir_match (
  input  logic [31:0] interval_i,
  input  logic [15:0] nominal_i,
  output logic        hit_o
);

  logic [34:0] scaled;
  logic [17:0] lo;
  logic [18:0] hi;

  // +/-20 percent window: 4*n <= 5*i <= 6*n
  assign scaled = {interval_i, 2'b00} + {3'b000, interval_i};
  assign lo     = {nominal_i, 2'b00};
  assign hi     = {1'b0, nominal_i, 2'b00} + {2'b00, nominal_i, 1'b0};
  assign hit_o  = (scaled >= {17'd0, lo}) && (scaled <= {16'd0, hi});

endmodule

/* hdl/nec_ir_core.sv */
module nec_ir_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [31:0]           edge_time_i,
  input  nec_ir_pkg::cfg_t      cfg_i,
  output nec_ir_pkg::frame_t    res_o
);

  logic [31:0] last_d, last_q;
  logic        data_d, data_q;
  logic [5:0]  cnt_d, cnt_q;
  logic [31:0] word_d, word_q;
  logic [31:0] interval;
  logic        hdr_hit, zero_hit, one_hit, is_one;

  always_comb begin
    if (edge_time_i > last_q) begin
      interval = edge_time_i - last_q;
    end else begin
      // counter wrapped or repeated timestamp
      interval = cfg_i.wrap_count - last_q + edge_time_i;
    end
  end

  nec_ir_match u_hdr (
    .interval_i (interval),
    .nominal_i  (cfg_i.header_nominal_us),
    .hit_o      (hdr_hit)
  );

  nec_ir_match u_zero (
    .interval_i (interval),
    .nominal_i  (cfg_i.zero_nominal_us),
    .hit_o      (zero_hit)
  );

  nec_ir_match u_one (
    .interval_i (interval),
    .nominal_i  (cfg_i.one_nominal_us),
    .hit_o      (one_hit)
  );

  // zero wins where the windows overlap
  assign is_one = !zero_hit && one_hit;

  always_comb begin
    last_d = last_q;
    data_d = data_q;
    cnt_d  = cnt_q;
    word_d = word_q;
    res_o  = '0;
    if (fire_i) begin
      last_d = edge_time_i;
      if (data_q) begin
        if (zero_hit || is_one) begin
          if (is_one) begin
            word_d = word_q | (nec_ir_pkg::MsbMask >> cnt_q[4:0]);
          end
          cnt_d = cnt_q + 6'd1;
          if (cnt_d == nec_ir_pkg::FrameBits) begin
            res_o.valid   = 1'b1;
            res_o.address = word_d[31:24];
            res_o.command = word_d[15:8];
            data_d        = 1'b0;
          end
        end else begin
          data_d = 1'b0;
        end
      end else if (hdr_hit) begin
        cnt_d  = '0;
        word_d = '0;
        data_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      data_q <= 1'b0;
      cnt_q  <= '0;
      word_q <= '0;
    end else begin
      last_q <= last_d;
      data_q <= data_d;
      cnt_q  <= cnt_d;
      word_q <= word_d;
    end
  end

endmodule

/* hdl/nec_ir_frame_decoder_top.sv */
// a frame's last item is registered at the input, its result then registered at the output
// one item per cycle unless the output stalls; frame state updates in a single register stage
// an item waits in the input register only while a finished result is held on the output
// reset (rst_ni low, asynchronous) empties both registers, returns the decoder to idle
// and loads the nominal intervals and wrap count with their defaults
module nec_ir_frame_decoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [nec_ir_pkg::CfgDataW-1:0]   cfg_data_i,
  nec_ir_edge_if.sink                       edge_i,
  nec_ir_frame_if.source                    frame_o
);

  nec_ir_pkg::cfg_t   cfg;
  nec_ir_pkg::frame_t res;

  logic        in_vld_d, in_vld_q;
  logic [31:0] edge_d, edge_q;
  logic        out_vld_d, out_vld_q;
  logic [7:0]  addr_d, addr_q;
  logic [7:0]  cmd_d, cmd_q;
  logic        fire;
  logic        in_acc;

  nec_ir_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the held item advances once the output slot is free or being taken
  assign fire         = in_vld_q && (!out_vld_q || frame_o.ready);
  assign edge_i.ready = !in_vld_q || fire;
  assign in_acc       = edge_i.valid && edge_i.ready;

  nec_ir_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .edge_time_i (edge_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    edge_d   = edge_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
      edge_d   = edge_i.edge_time_us;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    addr_d    = addr_q;
    cmd_d     = cmd_q;
    if (fire) begin
      out_vld_d = res.valid;
      if (res.valid) begin
        addr_d = res.address;
        cmd_d  = res.command;
      end
    end else if (frame_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    addr_q <= addr_d;
    cmd_q  <= cmd_d;
  end

  assign frame_o.valid   = out_vld_q;
  assign frame_o.address = addr_q;
  assign frame_o.command = cmd_q;

endmodule

/* hdl/nec_ir_chk.sv */
module nec_ir_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_address,
  input logic [7:0] out_command
);

  logic       in_acc;
  logic       out_new;
  logic       out_vld_q, out_rdy_q;
  logic [5:0] items_d, items_q;

  assign in_acc  = in_valid && in_ready;
  // a fresh result appears on the output
  assign out_new = out_valid && (!out_vld_q || out_rdy_q);

  always_comb begin
    items_d = items_q;
    if (out_new) begin
      items_d = in_acc ? 6'd1 : 6'd0;
    end else if (in_acc && (items_q != 6'h3F)) begin
      items_d = items_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_rdy_q <= 1'b0;
      items_q   <= '0;
    end else begin
      out_vld_q <= out_valid;
      out_rdy_q <= out_ready;
      items_q   <= items_d;
    end
  end

  // a frame needs a header and 32 bit items
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_new |-> (items_q >= 6'd30))
    else $error("result shown after too few items");

  a_rise_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result not two cycles after an accepted item");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_address) && $stable(out_command)))
    else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder_top nec_ir_chk u_nec_ir_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (edge_i.valid),
  .in_ready    (edge_i.ready),
  .out_valid   (frame_o.valid),
  .out_ready   (frame_o.ready),
  .out_address (frame_o.address),
  .out_command (frame_o.command)
);

/* tb/nec_ir_frame_decoder_top_tb.sv */
`timescale 1ns / 100ps

module nec_ir_frame_decoder_top_tb;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] command;
  } frame_bytes_t;

  // tracks the decoder state and queues the frames it must emit
  class nec_frame_predictor;
    logic [15:0]  hdr_nom;
    logic [15:0]  zero_nom;
    logic [15:0]  one_nom;
    logic [31:0]  wrap;
    logic [31:0]  last_stamp;
    bit           in_frame;
    logic [5:0]   bits_seen;
    logic [31:0]  word;
    frame_bytes_t frames_due[$];
    int unsigned  errors;

    function new();
      hdr_nom    = nec_ir_pkg::HeaderNominalRst;
      zero_nom   = nec_ir_pkg::ZeroNominalRst;
      one_nom    = nec_ir_pkg::OneNominalRst;
      wrap       = nec_ir_pkg::WrapCountRst;
      last_stamp = '0;
      in_frame   = 1'b0;
      bits_seen  = '0;
      word       = '0;
      errors     = 0;
    endfunction

    function void set_reg(nec_ir_pkg::cfg_idx_e idx, logic [31:0] data);
      case (idx)
        nec_ir_pkg::CFG_HEADER: hdr_nom  = data[15:0];
        nec_ir_pkg::CFG_ZERO:   zero_nom = data[15:0];
        nec_ir_pkg::CFG_ONE:    one_nom  = data[15:0];
        nec_ir_pkg::CFG_WRAP:   wrap     = data;
        default: ;
      endcase
    endfunction

    // +/-20 percent window, exact: 4*nom <= 5*ival <= 6*nom
    function bit fits(logic [31:0] ival, logic [15:0] nom);
      longint unsigned scaled;
      scaled = 64'(ival) * 64'd5;
      return scaled >= 64'(nom) * 64'd4 && scaled <= 64'(nom) * 64'd6;
    endfunction

    function void note_edge(logic [31:0] stamp);
      logic [31:0] ival;
      bit          is_zero;
      bit          is_one;
      if (stamp > last_stamp) begin
        ival = stamp - last_stamp;
      end else begin
        ival = wrap - last_stamp + stamp;
      end
      last_stamp = stamp;
      if (in_frame) begin
        is_zero = fits(ival, zero_nom);
        is_one  = !is_zero && fits(ival, one_nom);
        if (is_zero || is_one) begin
          if (is_one) word = word | (nec_ir_pkg::MsbMask >> bits_seen[4:0]);
          bits_seen = bits_seen + 6'd1;
          if (bits_seen == nec_ir_pkg::FrameBits) begin
            frames_due.push_back('{address: word[31:24], command: word[15:8]});
            in_frame = 1'b0;
          end
        end else begin
          in_frame = 1'b0;
        end
      end else if (fits(ival, hdr_nom)) begin
        bits_seen = '0;
        word      = '0;
        in_frame  = 1'b1;
      end
    endfunction

    function void check_frame(logic [7:0] address, logic [7:0] command);
      frame_bytes_t due;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: address %0h command %0h", address, command);
        errors++;
        return;
      end
      due = frames_due.pop_front();
      if (address !== due.address) begin
        $error("address: expected %0h, got %0h", due.address, address);
        errors++;
      end
      if (command !== due.command) begin
        $error("command: expected %0h, got %0h", due.command, command);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [nec_ir_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [nec_ir_pkg::CfgDataW-1:0] cfg_data;

  nec_ir_edge_if  edge_if ();
  nec_ir_frame_if frame_if ();

  nec_ir_frame_decoder_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .edge_i     (edge_if),
    .frame_o    (frame_if)
  );

  nec_frame_predictor frame_pred;
  logic [31:0]        stamp_now = '0;
  int unsigned        items_sent = 0;
  bit                 quiet = 1'b0;
  bit                 rush = 1'b0;
  bit                 hold_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned win_lo(logic [15:0] nom);
    return (4 * int'(nom) + 4) / 5;
  endfunction

  function automatic int unsigned win_hi(logic [15:0] nom);
    return (6 * int'(nom)) / 5;
  endfunction

  // random interval inside the window, boundaries favored
  function automatic int unsigned pick_ival(logic [15:0] nom);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return win_lo(nom);
    if (r == 1) return win_hi(nom);
    return $urandom_range(win_lo(nom), win_hi(nom));
  endfunction

  function automatic int unsigned noise_ival();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 20000);
      2: return win_lo(frame_pred.zero_nom) - 1;
      3: return win_hi(frame_pred.one_nom) + 1;
      default: return win_hi(frame_pred.hdr_nom) + 1;
    endcase
  endfunction

  // timestamp that gives the wanted interval, going over the wrap value when it can
  function automatic logic [31:0] next_stamp(int unsigned ival);
    logic [32:0] sum;
    sum = {1'b0, stamp_now} + 33'(ival);
    if (sum > {1'b0, frame_pred.wrap} && ival <= frame_pred.wrap &&
        stamp_now <= frame_pred.wrap) begin
      return ival - (frame_pred.wrap - stamp_now);
    end
    return sum[31:0];
  endfunction

  // called at a rising edge, returns at the edge that takes the item
  task automatic send_edge(logic [31:0] stamp);
    int unsigned gap;
    gap = (quiet || rush) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      edge_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_if.valid        <= 1'b1;
    edge_if.edge_time_us <= stamp;
    do @(negedge clk); while (!edge_if.ready);
    frame_pred.note_edge(stamp);
    stamp_now = stamp;
    items_sent++;
    @(posedge clk);
  endtask

  task automatic send_ival(int unsigned ival);
    send_edge(next_stamp(ival));
  endtask

  task automatic write_reg(nec_ir_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    frame_pred.set_reg(idx, data);
  endtask

  // upper bits of the 16-bit registers carry junk that must be dropped
  task automatic program_regs(logic [15:0] hdr, logic [15:0] zero, logic [15:0] one,
                              logic [31:0] wrap);
    write_reg(nec_ir_pkg::CFG_HEADER, {16'($urandom), hdr});
    write_reg(nec_ir_pkg::CFG_ZERO, {16'($urandom), zero});
    write_reg(nec_ir_pkg::CFG_ONE, {16'($urandom), one});
    write_reg(nec_ir_pkg::CFG_WRAP, wrap);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    edge_if.valid <= 1'b0;
    while (frame_pred.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_frame();
    int unsigned abort_at;
    int unsigned b;
    if (stamp_now > frame_pred.wrap) send_edge($urandom_range(0, frame_pred.wrap));
    send_ival(pick_ival(frame_pred.hdr_nom));
    abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 32;
    for (b = 0; b < 32; b++) begin
      if (b == abort_at) begin
        send_ival(noise_ival());
        break;
      end
      send_ival(pick_ival($urandom_range(0, 1) ? frame_pred.one_nom : frame_pred.zero_nom));
    end
  endtask

  task automatic run_items(int unsigned count, int unsigned rush_items);
    int unsigned target;
    int unsigned rush_end;
    int unsigned n;
    target   = items_sent + count;
    rush_end = items_sent + rush_items;
    while (items_sent < target) begin
      quiet = ($urandom_range(0, 6) == 0);
      rush  = (items_sent < rush_end);
      if ($urandom_range(0, 4) != 0) begin
        send_frame();
      end else begin
        for (n = $urandom_range(1, 3); n > 0; n--) begin
          if ($urandom_range(0, 1)) send_ival(noise_ival());
          else send_edge($urandom);
        end
      end
    end
    quiet = 1'b0;
    rush  = 1'b0;
  endtask

  // result side: per-item stall, one long hold-off on request
  initial begin
    int unsigned stall;
    frame_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 400;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        frame_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_if.ready <= 1'b1;
      do @(negedge clk); while (!frame_if.valid);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      frame_pred.check_frame(frame_if.address, frame_if.command);
    end
  end

  initial begin
    #3000000;
    $display("** nec_ir_frame_decoder_top: FAILED **");
    $finish;
  end

  initial begin
    frame_pred = new();
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= nec_ir_pkg::CFG_HEADER;
    cfg_data             <= '0;
    edge_if.valid        <= 1'b0;
    edge_if.edge_time_us <= '0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // reset values: same stamp, window edges, aborts, counter wrap
    send_edge(32'd0);
    send_ival(win_lo(frame_pred.hdr_nom) - 1);
    send_ival(win_hi(frame_pred.hdr_nom) + 1);
    send_ival(win_lo(frame_pred.hdr_nom));
    send_ival(win_lo(frame_pred.zero_nom));
    send_ival(win_hi(frame_pred.zero_nom));
    send_ival(win_lo(frame_pred.one_nom));
    send_ival(win_hi(frame_pred.one_nom));
    send_ival(win_hi(frame_pred.one_nom) + 1);
    send_ival(win_lo(frame_pred.zero_nom));
    send_ival(win_hi(frame_pred.hdr_nom));
    send_ival(win_lo(frame_pred.zero_nom) - 1);
    send_edge(32'hFFFF_FFF0);
    send_ival(win_lo(frame_pred.hdr_nom));
    send_edge(32'hFFFF_FFFF);
    run_items(300, 0);

    settle();
    program_regs(16'hFFFF, 16'd1, 16'hFFFF, 32'hFFFF_FFFF);
    run_items(310, 0);

    settle();
    program_regs(16'd1, 16'd3, 16'd2, 32'd1);
    run_items(310, 0);

    // zero and one windows overlap, counter wraps every 64k
    settle();
    program_regs(16'd13500, 16'd1000, 16'd1100, 32'h0001_0000);
    run_items(310, 0);

    // long result hold-off while items keep coming
    settle();
    program_regs(16'($urandom_range(5000, 20000)), 16'($urandom_range(300, 1500)),
                 16'($urandom_range(1600, 3000)), $urandom_range(100000, 32'hFFFF_FFFF));
    hold_req = 1'b1;
    run_items(310, 150);

    settle();
    program_regs(nec_ir_pkg::HeaderNominalRst, nec_ir_pkg::ZeroNominalRst,
                 nec_ir_pkg::OneNominalRst, nec_ir_pkg::WrapCountRst);
    run_items(310, 0);

    settle();
    if (frame_pred.errors == 0) begin
      $display("** nec_ir_frame_decoder_top: PASSED **");
    end else begin
      $display("** nec_ir_frame_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
